/* rtl/baro_temp_pressure_compensation_unit_macros.svh */
// assertion macros shared by the compensation unit checkers
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_MACROS_SVH

// antecedent implies consequent, checked outside reset
`define BTPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btpc check failed");

// expression never holds outside reset
`define BTPC_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("btpc check failed");

`endif

/* rtl/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// btpc_pkg
// types and constants of the barometric compensation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpc_pkg;

  localparam int DIV_STEPS = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_T1_T2 = 3'd0;
  localparam logic [2:0] CFG_T3    = 3'd1;
  localparam logic [2:0] CFG_P1_P2 = 3'd2;
  localparam logic [2:0] CFG_P3_P4 = 3'd3;
  localparam logic [2:0] CFG_P5_P6 = 3'd4;
  localparam logic [2:0] CFG_P7_P8 = 3'd5;
  localparam logic [2:0] CFG_P9    = 3'd6;

  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
  localparam logic [63:0] DEN_BIAS = 64'h0000_8000_0000_0000;
  localparam logic [20:0] P_FULL = 21'd1048576;
  localparam logic signed [16:0] NUM_SCALE = 17'sd3125;
  localparam logic [24:0] PRES_MAX = 25'h1FF_FFFF;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } btpc_in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_q24_8;
    logic               div_error;
  } btpc_out_t;

  // sideband into the divider
  typedef struct packed {
    logic               valid;
    logic signed [14:0] tc;
  } btpc_tag_t;

  // sideband out of the divider
  typedef struct packed {
    logic               valid;
    logic               err;
    logic signed [14:0] tc;
  } btpc_dtag_t;

endpackage

/* rtl/btpc_mul_ws.sv */
// ----------------------------------------------------------------------------
// btpc_mul_ws
// two-stage 64 x 17 signed multiply, low 64 bits of the product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_mul_ws (
  input  logic              clk,
  input  logic [63:0]       a,
  input  logic signed [16:0] b,
  output logic [63:0]       y
);
  import btpc_pkg::*;

  logic signed [49:0] plo_c;
  logic signed [48:0] phi_c;
  logic signed [49:0] plo;
  logic [31:0]        phi;

  assign plo_c = $signed({1'b0, a[31:0]}) * b;
  assign phi_c = $signed(a[63:32]) * b;

  always_ff @(posedge clk) begin
    plo <= plo_c;
    phi <= phi_c[31:0];
    y   <= {{14{plo[49]}}, plo} + {phi, 32'h0};
  end

endmodule

/* rtl/btpc_mul_ll.sv */
// ----------------------------------------------------------------------------
// btpc_mul_ll
// two-stage 64 x 64 multiply, low 64 bits of the product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_mul_ll (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);
  import btpc_pkg::*;

  logic [63:0] ll_c;
  logic [63:0] lh_c;
  logic [63:0] hl_c;
  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  assign ll_c = a[31:0] * b[31:0];
  assign lh_c = a[31:0] * b[63:32];
  assign hl_c = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    ll <= ll_c;
    lh <= lh_c[31:0];
    hl <= hl_c[31:0];
    y  <= ll + {lh + hl, 32'h0};
  end

endmodule

/* rtl/btpc_div.sv */
// ----------------------------------------------------------------------------
// btpc_div
// pipelined signed divide, one quotient bit per stage, truncates toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  btpc_pkg::btpc_tag_t   tag_in,
  input  logic [63:0]           num,
  input  logic [63:0]           den_prod,
  output btpc_pkg::btpc_dtag_t  tag_out,
  output logic [63:0]           quot
);
  import btpc_pkg::*;

  logic signed [63:0] den_sh;
  logic signed [30:0] den;
  logic               den_zero;

  logic               vld_q [0:DIV_STEPS];
  logic [30:0]        rem_q [0:DIV_STEPS];
  logic [63:0]        n_q   [0:DIV_STEPS];
  logic [30:0]        dv_q  [0:DIV_STEPS];
  logic               neg_q [0:DIV_STEPS];
  logic               err_q [0:DIV_STEPS];
  logic signed [14:0] tc_q  [0:DIV_STEPS];

  assign den_sh   = $signed(den_prod) >>> 33;
  assign den      = den_sh[30:0];
  assign den_zero = (den == 31'sd0);

  // operand conditioning: magnitudes and result sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= tag_in.valid;
    end
    rem_q[0] <= '0;
    n_q[0]   <= num[63] ? (64'h0 - num) : num;
    dv_q[0]  <= den_zero ? 31'd1 : (den[30] ? (31'h0 - den) : den);
    neg_q[0] <= num[63] ^ den[30];
    err_q[0] <= den_zero;
    tc_q[0]  <= tag_in.tc;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    assign trial = {rem_q[k], n_q[k][63]};
    assign diff  = trial - {1'b0, dv_q[k]};
    assign ge    = (trial >= {1'b0, dv_q[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
      rem_q[k+1] <= ge ? diff[30:0] : trial[30:0];
      n_q[k+1]   <= {n_q[k][62:0], ge};
      dv_q[k+1]  <= dv_q[k];
      neg_q[k+1] <= neg_q[k];
      err_q[k+1] <= err_q[k];
      tc_q[k+1]  <= tc_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= vld_q[DIV_STEPS];
    end
    tag_out.err <= err_q[DIV_STEPS];
    tag_out.tc  <= tc_q[DIV_STEPS];
    quot <= neg_q[DIV_STEPS] ? (64'h0 - n_q[DIV_STEPS]) : n_q[DIV_STEPS];
  end

endmodule

/* rtl/baro_temp_pressure_compensation_unit.sv */
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// fixed-point temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// One sample pair may be started in every cycle; busy is only high just
// after reset. Each result appears on result with done high for exactly
// one cycle, in start order; the receiver cannot stall, so it must take
// every strobe. The pipeline is the 64-stage restoring divider that forms
// the pressure quotient, together with its operand and output registers
// (66 stages), plus ten stages ahead of it (temperature polynomial,
// pressure quadratics, split multipliers) and seven behind it (final
// correction and saturation). Calibration registers are written through
// the cfg channel, which is always ready; write them only while no
// transaction is in flight. A zero divisor gives zero pressure with
// div_error set.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  btpc_pkg::btpc_in_t  item,
  output logic                done,
  output btpc_pkg::btpc_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import btpc_pkg::*;

  // calibration registers
  logic [31:0] cal_t1_t2;
  logic [15:0] cal_t3;
  logic [31:0] cal_p1_p2;
  logic [31:0] cal_p3_p4;
  logic [31:0] cal_p5_p6;
  logic [31:0] cal_p7_p8;
  logic [15:0] cal_p9;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  logic accept;

  // front pipeline valid bits and taps
  logic               vld   [1:10];
  logic [19:0]        adcp_q[1:7];
  logic signed [14:0] tc_q  [4:10];

  // stage 1: linear and square temperature terms
  logic signed [17:0] a_c;
  logic signed [16:0] b_c;
  logic signed [33:0] at2_c, at2_q;
  logic signed [33:0] bb_c;
  logic [31:0]        bb_q;

  // stage 2
  logic signed [33:0] at2_sh;
  logic signed [22:0] v1_c, v1_q;
  logic signed [36:0] v2p_c, v2p_q;

  // stage 3: fine temperature
  logic signed [36:0] v2_sh;
  logic signed [22:0] v2_c;
  logic signed [23:0] tfine_c, tfine_q;
  logic signed [24:0] x_c, x_q;

  // stage 4: squares and products of the fine offset, temperature output
  logic signed [49:0] xx_c;
  logic [49:0]        xx_q;
  logic signed [40:0] xp5_c, xp2_c;
  logic signed [40:0] xp5_q [4:6];
  logic signed [40:0] xp2_q [4:6];
  logic signed [26:0] t5_c, tsh_c;
  logic signed [14:0] tc_c;

  // stages 5 to 10: numerator and divisor
  logic [63:0]        wp6, dp3;
  logic signed [63:0] d3_sh;
  logic [63:0]        w_c, w_q, den0_c, den0_q;
  logic [20:0]        pc_c;
  logic [63:0]        num0_c, num0_q;
  logic [63:0]        dp9, dp10, nump10;

  // divider
  btpc_tag_t  div_tag;
  btpc_dtag_t div_out;
  logic [63:0] quot;

  // back pipeline: quadratic correction
  logic               pv   [1:6];
  logic               perr [1:6];
  logic signed [14:0] ptc  [1:6];
  logic [63:0]        pq   [1:4];
  logic signed [63:0] s_c;
  logic [63:0]        ss, c8raw, c9raw;
  logic signed [63:0] c8_sh, c9_sh, sum_sh;
  logic [63:0]        c8_q3, c8_q4, sum_q, pr_q;
  logic [63:0]        pr_c;
  logic [24:0]        pres_c;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t1_t2 <= '0;
      cal_t3    <= '0;
      cal_p1_p2 <= '0;
      cal_p3_p4 <= '0;
      cal_p5_p6 <= '0;
      cal_p7_p8 <= '0;
      cal_p9    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_T1_T2: cal_t1_t2 <= cfg_data;
        CFG_T3:    cal_t3    <= cfg_data[15:0];
        CFG_P1_P2: cal_p1_p2 <= cfg_data;
        CFG_P3_P4: cal_p3_p4 <= cfg_data;
        CFG_P5_P6: cal_p5_p6 <= cfg_data;
        CFG_P7_P8: cal_p7_p8 <= cfg_data;
        CFG_P9:    cal_p9    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign t1 = cal_t1_t2[15:0];
  assign t2 = cal_t1_t2[31:16];
  assign t3 = cal_t3;
  assign p1 = cal_p1_p2[15:0];
  assign p2 = cal_p1_p2[31:16];
  assign p3 = cal_p3_p4[15:0];
  assign p4 = cal_p3_p4[31:16];
  assign p5 = cal_p5_p6[15:0];
  assign p6 = cal_p5_p6[31:16];
  assign p7 = cal_p7_p8[15:0];
  assign p8 = cal_p7_p8[31:16];
  assign p9 = cal_p9;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 10; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[1] <= accept;
      for (int k = 2; k <= 10; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1
  assign a_c   = $signed({1'b0, item.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b_c   = $signed({1'b0, item.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign at2_c = a_c * t2;
  assign bb_c  = b_c * b_c;

  // stage 2
  assign at2_sh = at2_q >>> 11;
  assign v1_c   = at2_sh[22:0];
  assign v2p_c  = $signed({1'b0, bb_q[31:12]}) * t3;

  // stage 3
  assign v2_sh   = v2p_q >>> 14;
  assign v2_c    = v2_sh[22:0];
  assign tfine_c = v1_q + v2_c;
  assign x_c     = tfine_c - T_FINE_OFFSET;

  // stage 4: temperature in centidegrees, clamped
  assign xx_c  = x_q * x_q;
  assign xp5_c = x_q * p5;
  assign xp2_c = x_q * p2;
  assign t5_c  = tfine_q * 27'sd5 + 27'sd128;
  assign tsh_c = t5_c >>> 8;

  always_comb begin
    priority if (tsh_c < TEMP_MIN) begin
      tc_c = 15'(TEMP_MIN);
    end else if (tsh_c > TEMP_MAX) begin
      tc_c = 15'(TEMP_MAX);
    end else begin
      tc_c = tsh_c[14:0];
    end
  end

  always_ff @(posedge clk) begin
    at2_q   <= at2_c;
    bb_q    <= bb_c[31:0];
    v1_q    <= v1_c;
    v2p_q   <= v2p_c;
    tfine_q <= tfine_c;
    x_q     <= x_c;
    xx_q    <= xx_c;
    xp5_q[4] <= xp5_c;
    xp2_q[4] <= xp2_c;
    for (int k = 5; k <= 6; k++) begin
      xp5_q[k] <= xp5_q[k-1];
      xp2_q[k] <= xp2_q[k-1];
    end
    tc_q[4] <= tc_c;
    for (int k = 5; k <= 10; k++) begin
      tc_q[k] <= tc_q[k-1];
    end
    adcp_q[1] <= item.raw_pressure;
    for (int k = 2; k <= 7; k++) begin
      adcp_q[k] <= adcp_q[k-1];
    end
  end

  // stages 5 and 6: square of the offset times p6 and p3
  btpc_mul_ws u_mul_p6 (
    .clk (clk),
    .a   ({14'h0, xx_q}),
    .b   (17'(p6)),
    .y   (wp6)
  );

  btpc_mul_ws u_mul_p3 (
    .clk (clk),
    .a   ({14'h0, xx_q}),
    .b   (17'(p3)),
    .y   (dp3)
  );

  // stage 7: sum the numerator offset and the divisor quadratic
  assign d3_sh  = $signed(dp3) >>> 8;
  assign w_c    = wp6 + {{6{xp5_q[6][40]}}, xp5_q[6], 17'h0}
                + {{13{p4[15]}}, p4, 35'h0};
  assign den0_c = d3_sh + {{11{xp2_q[6][40]}}, xp2_q[6], 12'h0} + DEN_BIAS;

  // stage 8: numerator before scaling
  assign pc_c   = P_FULL - {1'b0, adcp_q[7]};
  assign num0_c = {12'h0, pc_c, 31'h0} - w_q;

  always_ff @(posedge clk) begin
    w_q    <= w_c;
    den0_q <= den0_c;
    num0_q <= num0_c;
    dp10   <= dp9;
  end

  // stages 8 and 9: divisor scale by p1
  btpc_mul_ws u_mul_p1 (
    .clk (clk),
    .a   (den0_q),
    .b   ($signed({1'b0, p1})),
    .y   (dp9)
  );

  // stages 9 and 10: numerator scale
  btpc_mul_ws u_mul_num (
    .clk (clk),
    .a   (num0_q),
    .b   (NUM_SCALE),
    .y   (nump10)
  );

  assign div_tag.valid = vld[10];
  assign div_tag.tc    = tc_q[10];

  btpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (div_tag),
    .num      (nump10),
    .den_prod (dp10),
    .tag_out  (div_out),
    .quot     (quot)
  );

  // back stages 1 and 2: square of the scaled quotient, p8 term
  assign s_c = $signed(quot) >>> 13;

  btpc_mul_ll u_mul_ss (
    .clk (clk),
    .a   (s_c),
    .b   (s_c),
    .y   (ss)
  );

  btpc_mul_ws u_mul_p8 (
    .clk (clk),
    .a   (quot),
    .b   (17'(p8)),
    .y   (c8raw)
  );

  // back stages 3 and 4: p9 term
  btpc_mul_ws u_mul_p9 (
    .clk (clk),
    .a   (ss),
    .b   (17'(p9)),
    .y   (c9raw)
  );

  assign c8_sh  = $signed(c8raw) >>> 19;
  assign c9_sh  = $signed(c9raw) >>> 25;
  assign sum_sh = $signed(sum_q) >>> 8;
  assign pr_c   = sum_sh + {{44{p7[15]}}, p7, 4'h0};

  // saturate to the output range
  always_comb begin
    priority if (pr_q[63]) begin
      pres_c = '0;
    end else if (pr_q[62:25] != '0) begin
      pres_c = PRES_MAX;
    end else begin
      pres_c = pr_q[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 6; k++) begin
        pv[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      pv[1] <= div_out.valid;
      for (int k = 2; k <= 6; k++) begin
        pv[k] <= pv[k-1];
      end
      done <= pv[6];
    end
    perr[1] <= div_out.err;
    ptc[1]  <= div_out.tc;
    for (int k = 2; k <= 6; k++) begin
      perr[k] <= perr[k-1];
      ptc[k]  <= ptc[k-1];
    end
    pq[1] <= quot;
    for (int k = 2; k <= 4; k++) begin
      pq[k] <= pq[k-1];
    end
    c8_q3 <= c8_sh;
    c8_q4 <= c8_q3;
    sum_q <= pq[4] + c9_sh + c8_q4;
    pr_q  <= pr_c;
    result.temperature_centi <= ptc[6];
    result.pressure_q24_8    <= perr[6] ? 25'h0 : pres_c;
    result.div_error         <= perr[6];
  end

endmodule

/* rtl/btpc_checker.sv */
// ----------------------------------------------------------------------------
// btpc_checker
// port-level checks of the compensation unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_unit_macros.svh"

module btpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input btpc_pkg::btpc_in_t  item,
  input logic                done,
  input btpc_pkg::btpc_out_t result,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [2:0]          cfg_index,
  input logic [31:0]         cfg_data
);
  import btpc_pkg::*;

  // every started transaction comes back after the fixed latency
  `BTPC_ASSERT_IMP(a_lat_fwd, clk, rst, start && !busy, ##83 done)
  // no result without a matching start
  `BTPC_ASSERT_IMP(a_lat_back, clk, rst, done, $past(start && !busy, 83))
  // zero divisor gives zero pressure
  `BTPC_ASSERT_IMP(a_err_zero, clk, rst, done && result.div_error, result.pressure_q24_8 == '0)
  // temperature stays clamped
  `BTPC_ASSERT_NEVER(a_temp_rng, clk, rst, done && (result.temperature_centi < 15'sd0 - 15'sd4000 || result.temperature_centi > 15'sd8500))

endmodule

bind baro_temp_pressure_compensation_unit btpc_checker u_btpc_checker (.*);
